### design/stable_insertion_priority_sorter_top_defines.svh
// ---------------------------------------------------------------------------
// Sorter assertion macros
// Shared check wrappers for the stable insertion priority sorter.
// ---------------------------------------------------------------------------
`ifndef STABLE_INSERTION_PRIORITY_SORTER_TOP_DEFINES_SVH
`define STABLE_INSERTION_PRIORITY_SORTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define SIPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sorter check failed");

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define SIPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sorter check failed");

`endif

### design/sips_pkg.sv
// ---------------------------------------------------------------------------
// Sorter package
// Sizes and controller/datapath interface types for the priority sorter.
// ---------------------------------------------------------------------------
package sips_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int PRIO_BITS = 4;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    // commands from the controller
    typedef struct packed {
        logic ins;    // insert the beat on the input ports
        logic drain;  // emit the head entry and shift the store down
    } t_cmd;

    // status back to the controller
    typedef struct packed {
        logic is_last;  // exactly one entry held
    } t_status;

endpackage

### design/sips_ctrl.sv
// ---------------------------------------------------------------------------
// Sorter controller
// Two-state sequencer: accept beats while idle, drain the store on set end.
// ---------------------------------------------------------------------------
module sips_ctrl
    import sips_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_set_end,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd.ins   = 1'b0;
        o_cmd.drain = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.ins = 1'b1;
                    if (i_set_end) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                if (i_status.is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### design/sips_dp.sv
// ---------------------------------------------------------------------------
// Sorter datapath
// Row of compare-and-shift cells holding the sorted store, plus result regs.
// ---------------------------------------------------------------------------
module sips_dp
    import sips_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [TAG_BITS-1:0]  i_packet_tag,
    input  logic [PRIO_BITS-1:0] i_packet_priority,
    output t_status              o_status,
    output logic                 o_valid,
    output logic [TAG_BITS-1:0]  o_out_tag,
    output logic [PRIO_BITS-1:0] o_out_priority,
    output logic                 o_out_last,
    output logic                 o_dropped_flag
);

    logic [TAG_BITS-1:0]  r_tag  [DEPTH];
    logic [PRIO_BITS-1:0] r_prio [DEPTH];
    logic [CNT_BITS-1:0]  r_count;
    logic                 r_ovf;
    logic                 r_valid;
    logic [TAG_BITS-1:0]  r_out_tag;
    logic [PRIO_BITS-1:0] r_out_prio;
    logic                 r_out_last;
    logic                 r_out_drop;

    logic [DEPTH-1:0]     w_gt;
    logic                 w_full;
    logic                 w_write;

    // an empty cell counts as greater, so w_gt is zeros then ones
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_gt[i] = (CNT_BITS'(i) >= r_count) || (r_prio[i] > i_packet_priority);
        end
    end

    assign w_full  = (r_count == CNT_BITS'(DEPTH));
    assign w_write = i_cmd.ins && !w_full;

    assign o_status.is_last = (r_count == CNT_BITS'(1));

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (w_write && w_gt[g]) begin
                if (g == 0) begin
                    r_tag[g]  <= i_packet_tag;
                    r_prio[g] <= i_packet_priority;
                end else if (!w_gt[(g > 0) ? g - 1 : 0]) begin
                    r_tag[g]  <= i_packet_tag;
                    r_prio[g] <= i_packet_priority;
                end else begin
                    r_tag[g]  <= r_tag[(g > 0) ? g - 1 : 0];
                    r_prio[g] <= r_prio[(g > 0) ? g - 1 : 0];
                end
            end else if (i_cmd.drain && (g < DEPTH - 1)) begin
                r_tag[g]  <= r_tag[(g < DEPTH - 1) ? g + 1 : g];
                r_prio[g] <= r_prio[(g < DEPTH - 1) ? g + 1 : g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.drain;
            if (w_write) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (i_cmd.drain) begin
                r_count <= r_count - CNT_BITS'(1);
            end
            if (i_cmd.ins && w_full) begin
                r_ovf <= 1'b1;
            end else if (i_cmd.drain && o_status.is_last) begin
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drain) begin
            r_out_tag  <= r_tag[0];
            r_out_prio <= r_prio[0];
            r_out_last <= o_status.is_last;
            r_out_drop <= r_ovf;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_tag      = r_out_tag;
    assign o_out_priority = r_out_prio;
    assign o_out_last     = r_out_last;
    assign o_dropped_flag = r_out_drop;

endmodule

### design/stable_insertion_priority_sorter_top.sv
// ---------------------------------------------------------------------------
// Stable insertion priority sorter
// Collects packets into a store sorted by ascending priority, ties kept in
// arrival order, and emits the whole sorted run when a set-end beat lands.
// ---------------------------------------------------------------------------
//
//  channel   handshake          payload
//  --------  -----------------  ------------------------------------------
//  input     start && !busy     i_packet_tag, i_packet_priority, i_set_end
//  result    o_valid (strobe)   o_out_tag, o_out_priority, o_out_last,
//                               o_dropped_flag
//
//  Each beat without set end is inserted directly by the compare-and-
//  shift cells, so beats may follow back to back while busy stays low.
//  A set-end beat is inserted, then busy stays high while the store
//  drains one entry a cycle until all entries held (1..DEPTH) are out;
//  results follow in the next cycle, one per cycle, on the registered output.
//  Synchronous active-low reset empties the store and clears the overflow.
//  The receiver cannot stall: every result is shown for one cycle only.
// ---------------------------------------------------------------------------
`include "stable_insertion_priority_sorter_top_defines.svh"

module stable_insertion_priority_sorter_top
    import sips_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [TAG_BITS-1:0]  i_packet_tag,
    input  logic [PRIO_BITS-1:0] i_packet_priority,
    input  logic                 i_set_end,
    output logic                 o_valid,
    output logic [TAG_BITS-1:0]  o_out_tag,
    output logic [PRIO_BITS-1:0] o_out_priority,
    output logic                 o_out_last,
    output logic                 o_dropped_flag
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: decide insert or drain each cycle
    sips_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_set_end (i_set_end),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_busy    (busy)
    );

    // store cells, fill count, overflow mark and result registers
    sips_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_packet_tag      (i_packet_tag),
        .i_packet_priority (i_packet_priority),
        .o_status          (w_status),
        .o_valid           (o_valid),
        .o_out_tag         (o_out_tag),
        .o_out_priority    (o_out_priority),
        .o_out_last        (o_out_last),
        .o_dropped_flag    (o_dropped_flag)
    );

    // a set-end beat always starts a drain
    `SIPS_ASSERT_NEXT(a_end_starts_drain, start && !busy && i_set_end, busy)
    // results of one run come in an unbroken stream
    `SIPS_ASSERT_NEXT(a_run_contiguous, o_valid && !o_out_last, o_valid)
    // the final result of a run is shown once the controller is idle again
    `SIPS_ASSERT_NOW(a_last_frees_input, o_valid && o_out_last, !busy)

endmodule
